[hw/rtl/brsa_pkg.sv]
package brsa_pkg;

  // Array geometry
  localparam int CAPACITY  = 1024;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = CAPACITY / WORD_BITS;
  localparam int ELEM_W    = 32;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int WSEL_W    = 4;
  localparam int BSEL_W    = 6;
  localparam int POS_W     = CNT_W + 1;
  localparam int PCNT_W    = BSEL_W + 1;

  // Request commands
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_GET    = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_RANGE = 2'd1;
  localparam status_t STAT_ORDER = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAPACITY);

  // Controller to datapath
  typedef struct packed {
    logic latch;   // capture the accepted request
    logic eval;    // capture result fields of the held request
    logic clear;   // start a new array
    logic append;  // commit the held append
    logic read;    // read the element store at the rank position
    logic load;    // move the result into the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_req;
    logic app_ok;
    logic rd_hit;
  } dp_stat_t;

endpackage

[hw/rtl/brsa_in_if.sv]
interface brsa_in_if;
  logic                         valid;
  logic                         ready;
  brsa_pkg::cmd_t               cmd;
  logic [brsa_pkg::IDX_W-1:0]   element_index;
  logic [brsa_pkg::ELEM_W-1:0]  element_value;

  modport source (output valid, cmd, element_index, element_value, input ready);
  modport sink   (input valid, cmd, element_index, element_value, output ready);
endinterface

[hw/rtl/brsa_out_if.sv]
interface brsa_out_if;
  logic                         valid;
  logic                         ready;
  brsa_pkg::status_t            status;
  logic                         found;
  logic [brsa_pkg::ELEM_W-1:0]  element_out;
  logic [brsa_pkg::CNT_W-1:0]   stored_count;

  modport source (output valid, status, found, element_out, stored_count, input ready);
  modport sink   (input valid, status, found, element_out, stored_count, output ready);
endinterface

[hw/rtl/bitmap_rank_sparse_array.sv]
// Sparse array of up to 1024 32-bit elements addressed by a 10-bit index. Presence is kept
// as sixteen 64-bit bitmap words in flops, each with the element count at the time its
// first bit was set; elements are packed in append order in a 1024-entry single-port RAM.
// A request is clear, append (indices must rise strictly since the last clear, else status
// 2) or get (word base plus a popcount of the lower bits selects the element); an append
// or get index at or beyond cap_r gives status 1. Every request passes through accept,
// evaluate (bitmap select, popcount and element store access) and result load; a result
// waiting on out_ch holds the result-load step until the output register is free.
// No clearing pass is needed after reset: bitmap words reset to zero and gate every read.
module bitmap_rank_sparse_array (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [brsa_pkg::CNT_W-1:0]  cfg_wdata,
  brsa_in_if.sink                     in_ch,
  brsa_out_if.source                  out_ch
);

  brsa_pkg::ctl_cmd_t ctl_cmd;
  brsa_pkg::dp_stat_t dp_stat;
  logic               in_ready;
  logic               out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  brsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  brsa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctl_cmd),
    .stat        (dp_stat),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_cmd      (in_ch.cmd),
    .in_index    (in_ch.element_index),
    .in_value    (in_ch.element_value),
    .out_status  (out_ch.status),
    .out_found   (out_ch.found),
    .out_element (out_ch.element_out),
    .out_count   (out_ch.stored_count)
  );

endmodule

[hw/rtl/brsa_ram.sv]
module brsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one entry, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/brsa_ctrl.sv]
module brsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  brsa_pkg::dp_stat_t  stat,
  output brsa_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // Decode commands from state and datapath status
  always_comb begin
    cmd        = '0;
    cmd.latch  = (state_r == ST_IDLE) && in_valid;
    cmd.eval   = (state_r == ST_EVAL);
    cmd.clear  = (state_r == ST_EVAL) && stat.clr_req;
    cmd.append = (state_r == ST_EVAL) && stat.app_ok;
    cmd.read   = (state_r == ST_EVAL) && stat.rd_hit;
    cmd.load   = (state_r == ST_RESULT) && slot_free;
  end

  // Next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.eval)
    else $error("accepted request not evaluated next cycle");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> slot_free)
    else $error("result loaded over a waiting result");

  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.clear, cmd.append, cmd.read}) <= 1)
    else $error("more than one state update in one cycle");

endmodule

[hw/rtl/brsa_dp.sv]
module brsa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brsa_pkg::ctl_cmd_t            cmd,
  output brsa_pkg::dp_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [brsa_pkg::CNT_W-1:0]    cfg_wdata,
  input  brsa_pkg::cmd_t                in_cmd,
  input  logic [brsa_pkg::IDX_W-1:0]    in_index,
  input  logic [brsa_pkg::ELEM_W-1:0]   in_value,
  output brsa_pkg::status_t             out_status,
  output logic                          out_found,
  output logic [brsa_pkg::ELEM_W-1:0]   out_element,
  output logic [brsa_pkg::CNT_W-1:0]    out_count
);

  // Held request
  brsa_pkg::cmd_t                  req_cmd_r;
  logic [brsa_pkg::IDX_W-1:0]      req_idx_r;
  logic [brsa_pkg::ELEM_W-1:0]     req_val_r;

  // Array state
  logic [brsa_pkg::WORD_BITS-1:0]  bitmap_r [brsa_pkg::NUM_WORDS];
  logic [brsa_pkg::CNT_W-1:0]      base_r   [brsa_pkg::NUM_WORDS];
  logic [brsa_pkg::CNT_W-1:0]      count_r;
  logic [brsa_pkg::IDX_W-1:0]      last_r;
  logic [brsa_pkg::CNT_W-1:0]      cap_r;

  // Result fields
  brsa_pkg::status_t               res_status_r;
  logic                            res_found_r;
  logic                            res_hit_r;
  brsa_pkg::status_t               out_status_r;
  logic                            out_found_r;
  logic [brsa_pkg::ELEM_W-1:0]     out_element_r;
  logic [brsa_pkg::CNT_W-1:0]      out_count_r;

  logic [brsa_pkg::WSEL_W-1:0]     wsel;
  logic [brsa_pkg::BSEL_W-1:0]     bsel;
  logic [brsa_pkg::WORD_BITS-1:0]  word;
  logic [brsa_pkg::WORD_BITS-1:0]  below;
  logic [brsa_pkg::PCNT_W-1:0]     rank;
  logic [brsa_pkg::POS_W-1:0]      pos;
  logic                            range_err;
  logic                            order_err;
  logic                            bit_set;
  logic                            is_append;
  logic                            is_get;
  brsa_pkg::status_t               status_nxt;
  logic [brsa_pkg::ELEM_W-1:0]     ram_rdata;
  logic [brsa_pkg::IDX_W-1:0]      ram_addr;

  // Count set bits: per byte, then across bytes
  function automatic logic [brsa_pkg::PCNT_W-1:0] ones_in(
    input logic [brsa_pkg::WORD_BITS-1:0] w
  );
    logic [3:0]                     byte_cnt [8];
    logic [brsa_pkg::PCNT_W-1:0]    total;
    total = '0;
    for (int i = 0; i < 8; i++) begin
      byte_cnt[i] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt[i] = byte_cnt[i] + 4'(w[i*8+j]);
      end
    end
    for (int i = 0; i < 8; i++) begin
      total = total + brsa_pkg::PCNT_W'(byte_cnt[i]);
    end
    return total;
  endfunction

  // Locate the word and bit of the held index
  assign wsel  = req_idx_r[brsa_pkg::IDX_W-1:brsa_pkg::BSEL_W];
  assign bsel  = req_idx_r[brsa_pkg::BSEL_W-1:0];
  assign word  = bitmap_r[wsel];
  assign below = word & ~({brsa_pkg::WORD_BITS{1'b1}} << bsel);
  assign rank  = ones_in(below);
  assign pos   = brsa_pkg::POS_W'(base_r[wsel]) + brsa_pkg::POS_W'(rank);
  assign bit_set = word[bsel];

  // Check range and append order
  assign range_err = {1'b0, req_idx_r} >= cap_r;
  assign order_err = (count_r != '0) && (req_idx_r <= last_r);
  assign is_append = (req_cmd_r == brsa_pkg::CMD_APPEND);
  assign is_get    = (req_cmd_r == brsa_pkg::CMD_GET);

  always_comb begin
    priority if ((is_append || is_get) && range_err) begin
      status_nxt = brsa_pkg::STAT_RANGE;
    end else if (is_append && order_err) begin
      status_nxt = brsa_pkg::STAT_ORDER;
    end else begin
      status_nxt = brsa_pkg::STAT_OK;
    end
  end

  assign stat.clr_req = (req_cmd_r == brsa_pkg::CMD_CLEAR);
  assign stat.app_ok  = is_append && !range_err && !order_err
                        && (count_r < brsa_pkg::CNT_W'(brsa_pkg::CAPACITY));
  assign stat.rd_hit  = is_get && !range_err && bit_set
                        && (pos < brsa_pkg::POS_W'(brsa_pkg::CAPACITY));

  // Capture request and results; no reset needed on payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_cmd_r <= in_cmd;
      req_idx_r <= in_index;
      req_val_r <= in_value;
    end
    if (cmd.eval) begin
      res_status_r <= status_nxt;
      res_found_r  <= is_get && !range_err && bit_set;
      res_hit_r    <= stat.rd_hit;
    end
    if (cmd.load) begin
      out_status_r  <= res_status_r;
      out_found_r   <= res_found_r;
      out_element_r <= res_hit_r ? ram_rdata : '0;
      out_count_r   <= count_r;
    end
    if (cmd.append && (word == '0)) begin
      base_r[wsel] <= count_r;
    end
  end

  // Update array control state and capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < brsa_pkg::NUM_WORDS; i++) begin
        bitmap_r[i] <= '0;
      end
      count_r <= '0;
      last_r  <= '0;
      cap_r   <= brsa_pkg::CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        for (int i = 0; i < brsa_pkg::NUM_WORDS; i++) begin
          bitmap_r[i] <= '0;
        end
        count_r <= '0;
        last_r  <= '0;
      end else if (cmd.append) begin
        bitmap_r[wsel][bsel] <= 1'b1;
        count_r              <= count_r + 1'b1;
        last_r               <= req_idx_r;
      end
    end
  end

  // Element store: append writes at the count, get reads at the rank
  assign ram_addr = cmd.append ? count_r[brsa_pkg::IDX_W-1:0]
                               : pos[brsa_pkg::IDX_W-1:0];

  brsa_ram #(
    .WIDTH (brsa_pkg::ELEM_W),
    .DEPTH (brsa_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.append),
    .re    (cmd.read),
    .addr  (ram_addr),
    .wdata (req_val_r),
    .rdata (ram_rdata)
  );

  assign out_status  = out_status_r;
  assign out_found   = out_found_r;
  assign out_element = out_element_r;
  assign out_count   = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= brsa_pkg::CNT_W'(brsa_pkg::CAPACITY))
    else $error("element count beyond capacity");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not advance the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0) && (last_r == '0))
    else $error("clear left elements behind");

endmodule
